// ----- rtl/core/gbre_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbre_pkg: shared types and constants
// item structs, action codes and sizes for the row expansion block
// ----------------------------------------------------------------------------
package gbre_pkg;

  localparam int MAX_ROWS = 256;
  localparam int MAX_COLS = 64;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int SYM_W    = 4;
  localparam int CFG_W    = 64;
  localparam int CFG_IDX_W = 3;

  localparam logic [2:0] REG_ROW_COUNT   = 3'd0;
  localparam logic [2:0] REG_COL_COUNT   = 3'd1;
  localparam logic [2:0] REG_WIDTH_FLOOR = 3'd2;
  localparam logic [2:0] REG_CAND_THR    = 3'd3;
  localparam logic [2:0] REG_COL_ENABLE  = 3'd4;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_FLAG  = 2'd1;
  localparam logic [1:0] ACT_START = 2'd2;
  localparam logic [1:0] ACT_READ  = 2'd3;

  localparam logic KIND_SUMMARY = 1'b0;
  localparam logic KIND_READ    = 1'b1;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] row_sel;
    logic [5:0] col_sel;
    logic [3:0] symbol;
    logic       candidate_flag;
    logic [7:0] second_seed;
    logic [6:0] seed_score;
    logic [7:0] read_position;
  } in_item_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] gene_row;
    logic [8:0] kept_count;
    logic [6:0] top_score;
  } out_item_t;

endpackage

// ----- rtl/core/greedy_bicluster_row_expansion_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_bicluster_row_expansion_top: greedy bicluster row expansion
// loads a symbol matrix and candidate flags, grows a block from two seed rows
// ----------------------------------------------------------------------------
// channel   signals                          handshake
// input     start, busy, in_item             accepted when start & !busy
// result    out_valid, out_item              one-cycle strobe, no stall
// config    cfg_we, cfg_index, cfg_data      written when cfg_we is high
//
// load, flag: taken while idle, busy stays low. read: the block goes busy for the list memory read, the
// result strobe follows in the next cycle
// start: two seed passes over the columns; every added row then costs a scan
// over the flagged rows (unflagged rows are skipped), a decision state and a
// narrowing pass over the columns; the one-word-per-cycle matrix port sets the
// rate; the summary strobe follows the done cycle
// reset clears control, candidate flags, consensus valid bits and summary
// registers at once; the matrix and row list need no clearing. results cannot be stalled
// ----------------------------------------------------------------------------
module greedy_bicluster_row_expansion_top
  import gbre_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_item,
  output logic                 out_valid,
  output out_item_t            out_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_SEED  = 8'b0000_0010,  // consensus from the two seeds, one column a cycle
    ST_SCAN  = 8'b0000_0100,  // match count over rows x cols
    ST_DEC   = 8'b0000_1000,  // pick best, score, append
    ST_NARR  = 8'b0001_0000,  // narrow consensus by added row
    ST_DONE  = 8'b0010_0000,
    ST_READ  = 8'b0100_0000
  } state_t;

  state_t state;

  // configuration
  logic [8:0]  row_count;
  logic [6:0]  col_count;
  logic [6:0]  width_floor;
  logic [6:0]  cand_floor;
  logic [63:0] column_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count      <= 9'd256;
      col_count      <= 7'd64;
      width_floor    <= 7'd1;
      cand_floor     <= 7'd2;
      column_enable  <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW_COUNT:   row_count      <= cfg_data[8:0];
        REG_COL_COUNT:   col_count      <= cfg_data[6:0];
        REG_WIDTH_FLOOR: width_floor    <= cfg_data[6:0];
        REG_CAND_THR:    cand_floor     <= cfg_data[6:0];
        REG_COL_ENABLE:  column_enable  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [8:0] nr;
  logic [6:0] nc;
  assign nr = (row_count > 9'd256) ? 9'd256 : row_count;
  assign nc = (col_count > 7'd64) ? 7'd64 : col_count;

  // symbol matrix memory, one port each way, registered read
  logic [SYM_W-1:0] mem [MAX_ROWS*MAX_COLS];
  logic [ROW_W+COL_W-1:0] rd_addr;
  logic [SYM_W-1:0] rd_data;
  logic mem_we;

  assign mem_we = start && !busy && in_item.action == ACT_LOAD;

  always_ff @(posedge clk) begin
    if (mem_we) mem[{in_item.row_sel, in_item.col_sel}] <= in_item.symbol;
    rd_data <= mem[rd_addr];
  end

  // kept row list memory
  logic [7:0] glist [MAX_ROWS];
  logic       gl_we;
  logic [7:0] gl_waddr, gl_wdata, gl_raddr, gl_rdata;

  always_ff @(posedge clk) begin
    if (gl_we) glist[gl_waddr] <= gl_wdata;
    gl_rdata <= glist[gl_raddr];
  end

  logic [MAX_ROWS-1:0] cflag;
  logic [SYM_W-1:0]    cons [MAX_COLS];
  logic [MAX_COLS-1:0] cons_ok;    // consensus column holds a nonzero symbol
  logic [8:0] gene_total;
  logic [6:0] score_reg;

  // sequencer state
  logic [7:0] seed1, seed2;
  logic [8:0] size;
  logic [7:0] keep;
  logic [8:0] row;        // scan row
  logic [6:0] col;        // address column
  logic [5:0] pcol;       // column whose data is arriving
  logic       pvalid;
  logic       phase;      // seed pass: 0 first seed, 1 second
  logic [SYM_W-1:0] sym1 [MAX_COLS];
  logic [6:0] cnt;
  logic       found;
  logic [6:0] best_cnt;
  logic [7:0] best_row;
  logic [7:0] rd_pos;

  logic [5:0] pc;
  assign pc = pcol;

  // consensus and first seed symbols, read alongside the matrix word
  logic [SYM_W-1:0] cons_rd, sym1_rd;

  always_ff @(posedge clk) begin
    cons_rd <= cons[col[5:0]];
    sym1_rd <= sym1[col[5:0]];
  end

  always_comb begin
    rd_addr = {seed1, col[5:0]};
    case (state)
      ST_SEED: rd_addr = {(phase ? seed2 : seed1), col[5:0]};
      ST_SCAN: rd_addr = {row[7:0], col[5:0]};
      ST_NARR: rd_addr = {best_row, col[5:0]};
      default: rd_addr = {seed1, col[5:0]};
    endcase
  end

  // gene list write port
  always_comb begin
    gl_we = 1'b0;
    gl_waddr = 8'd0;
    gl_wdata = 8'd0;
    if (state == ST_IDLE && start && in_item.action == ACT_START) begin
      gl_we = 1'b1; gl_waddr = 8'd0; gl_wdata = in_item.row_sel;
    end else if (state == ST_SEED && !phase && col == 7'd0) begin
      gl_we = 1'b1; gl_waddr = 8'd1; gl_wdata = seed2;
    end else if (state == ST_DEC && found && best_cnt >= width_floor) begin
      gl_we = 1'b1; gl_waddr = size[7:0]; gl_wdata = best_row;
    end
  end
  assign gl_raddr = in_item.read_position;

  assign busy = (state != ST_IDLE);

  logic [6:0] cur;
  assign cur = ({2'b0, best_cnt} > size) ? size[6:0] : best_cnt;

  logic match_hit;
  assign match_hit = cons_ok[pc] && cons_rd == rd_data;

  // strobe follows the read and done cycles
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else     out_valid <= (state == ST_READ) || (state == ST_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cflag      <= '0;
      gene_total <= 9'd0;
      score_reg  <= 7'd0;
      pvalid     <= 1'b0;
      cons_ok    <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            case (in_item.action)
              ACT_FLAG: cflag[in_item.row_sel] <= in_item.candidate_flag;
              ACT_START: begin
                seed1 <= in_item.row_sel;
                seed2 <= in_item.second_seed;
                score_reg <= (in_item.seed_score < 7'd2) ? in_item.seed_score : 7'd2;
                cflag <= cflag &
                         ~(({{(MAX_ROWS-1){1'b0}}, 1'b1} << in_item.row_sel) |
                           ({{(MAX_ROWS-1){1'b0}}, 1'b1} << in_item.second_seed));
                cons_ok <= '0;
                col <= 7'd0; phase <= 1'b0; pvalid <= 1'b0;
                size <= 9'd2; keep <= 8'd1;
                state <= ST_SEED;
              end
              ACT_READ: begin
                rd_pos <= in_item.read_position;
                state <= ST_READ;
              end
              default: ;
            endcase
          end
        end
        ST_READ: begin
          out_item.result_kind <= KIND_READ;
          out_item.gene_row <= ({1'b0, rd_pos} < gene_total) ? gl_rdata : 8'd0;
          out_item.kept_count <= gene_total;
          out_item.top_score <= score_reg;
          state <= ST_IDLE;
        end
        ST_SEED: begin
          // data of the previous address arrives in the cycle after it
          if (pvalid) begin
            if (!phase) sym1[pc] <= rd_data;
            else if (rd_data != '0 && rd_data == sym1_rd && column_enable[pc]) begin
              cons[pc] <= rd_data;
              cons_ok[pc] <= 1'b1;
            end
          end
          pcol <= col[5:0]; pvalid <= (col < nc);
          if (col < nc) col <= col + 7'd1;
          else if (!pvalid) begin
            // pass drained
            col <= 7'd0;
            if (!phase) phase <= 1'b1;
            else begin
              if (nr <= size) state <= ST_DONE;
              else begin
                row <= 9'd0; cnt <= 7'd0; found <= 1'b0; best_cnt <= 7'd0;
                best_row <= 8'd0; state <= ST_SCAN;
              end
            end
          end
        end
        ST_SCAN: begin
          if (!cflag[row[7:0]]) begin
            row <= row + 9'd1;
            col <= 7'd0; pvalid <= 1'b0; cnt <= 7'd0;
            if (row + 9'd1 >= nr) state <= ST_DEC;
          end else begin
            if (pvalid && match_hit) cnt <= cnt + 7'd1;
            pcol <= col[5:0]; pvalid <= (col < nc);
            if (col < nc) col <= col + 7'd1;
            else if (!pvalid) begin
              // row finished, cnt final
              if (cnt < cand_floor) cflag[row[7:0]] <= 1'b0;
              if (!found || cnt > best_cnt) begin
                found <= 1'b1; best_cnt <= cnt; best_row <= row[7:0];
              end
              cnt <= 7'd0; col <= 7'd0;
              row <= row + 9'd1;
              if (row + 9'd1 >= nr) state <= ST_DEC;
            end
          end
        end
        ST_DEC: begin
          if (!found || best_cnt < width_floor) state <= ST_DONE;
          else begin
            if (cur >= score_reg) begin
              score_reg <= cur; keep <= size[7:0];
            end
            size <= size + 9'd1;
            cflag[best_row] <= 1'b0;
            col <= 7'd0; pvalid <= 1'b0;
            state <= ST_NARR;
          end
        end
        ST_NARR: begin
          if (pvalid && cons_ok[pc] && cons_rd != rd_data) cons_ok[pc] <= 1'b0;
          pcol <= col[5:0]; pvalid <= (col < nc);
          if (col < nc) col <= col + 7'd1;
          else if (!pvalid) begin
            if (size >= nr) state <= ST_DONE;
            else begin
              row <= 9'd0; col <= 7'd0; cnt <= 7'd0; found <= 1'b0;
              best_cnt <= 7'd0; best_row <= 8'd0; state <= ST_SCAN;
            end
          end
        end
        ST_DONE: begin
          gene_total <= {1'b0, keep} + 9'd1;
          out_item.result_kind <= KIND_SUMMARY;
          out_item.gene_row <= 8'd0;
          out_item.kept_count <= {1'b0, keep} + 9'd1;
          out_item.top_score <= score_reg;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/gbre_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbre_checker: port-level checks
// watches handshake and result strobes of the row expansion block
// ----------------------------------------------------------------------------
module gbre_checker
  import gbre_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      start,
  input logic      busy,
  input in_item_t  in_item,
  input logic      out_valid,
  input out_item_t out_item
);

  // a start or read item makes the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (in_item.action == ACT_START || in_item.action == ACT_READ)
    |=> busy)
    else $error("start check");

  // results come only while busy was set
  a_res_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $past(busy))
    else $error("result without work");

  // one result per item: strobe never high in consecutive cycles
  a_single: assert property (@(posedge clk) disable iff (rst)
    out_valid |=> !out_valid)
    else $error("double strobe");

  // summary never names a row
  a_summary_row: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.result_kind == KIND_SUMMARY |-> out_item.gene_row == 8'd0)
    else $error("summary row nonzero");

  // score never exceeds the column maximum of 64
  a_score: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.top_score <= 7'd64)
    else $error("score out of range");

endmodule

bind greedy_bicluster_row_expansion_top gbre_checker u_gbre_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .in_item(in_item),
  .out_valid(out_valid), .out_item(out_item)
);

// ----- test/tb_greedy_bicluster_row_expansion_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_greedy_bicluster_row_expansion_top: self-checking bench for row expansion
// phases of matrix loads, flag writes, seeded expansions and kept row reads
// run under several register settings; a behavioral copy of the expansion
// predicts every summary and read result, which the monitor checks in order
// ----------------------------------------------------------------------------
module tb_greedy_bicluster_row_expansion_top;
  import gbre_pkg::*;

  localparam int STALL_LIMIT = 2000000;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  in_item_t             in_item;
  logic                 out_valid;
  out_item_t            out_item;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  greedy_bicluster_row_expansion_top uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state, kept in step with the block
  logic [3:0]  sym_mem [MAX_ROWS][MAX_COLS];
  logic        cand [MAX_ROWS];
  logic [3:0]  consensus [MAX_COLS];
  logic [7:0]  kept_rows [MAX_ROWS];
  int unsigned kept_total;
  int unsigned score_now;
  int unsigned rc_reg, cc_reg, minw_reg, thr_reg;
  logic [63:0] colen_reg;

  // which elements the stimulus has loaded so far
  logic [63:0] loaded [MAX_ROWS];

  in_item_t    pending_items [$];
  out_item_t   expected_results [$];
  int          fail_count;
  int          burst_left, gap_left;
  int          stall_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  function automatic int unsigned match_total(int unsigned r, int unsigned nc);
    int unsigned n;
    n = 0;
    for (int c = 0; c < nc; c++)
      if (consensus[c] != 0 && consensus[c] == sym_mem[r][c]) n++;
    return n;
  endfunction

  function automatic void grow_block(int unsigned s1, int unsigned s2, int unsigned sc);
    int unsigned nr, nc, size, keep, best_cnt, best_row, n, cur;
    bit found;
    nr = (rc_reg > MAX_ROWS) ? MAX_ROWS : rc_reg;
    nc = (cc_reg > MAX_COLS) ? MAX_COLS : cc_reg;
    size = 2;
    keep = 1;
    for (int c = 0; c < MAX_COLS; c++) consensus[c] = 4'd0;
    // consensus: shared nonzero symbol of both seeds on enabled columns
    for (int c = 0; c < nc; c++)
      if (sym_mem[s1][c] != 0 && sym_mem[s1][c] == sym_mem[s2][c] && colen_reg[c])
        consensus[c] = sym_mem[s1][c];
    kept_rows[0] = s1[7:0];
    kept_rows[1] = s2[7:0];
    cand[s1] = 1'b0;
    cand[s2] = 1'b0;
    score_now = (sc < 2) ? sc : 2;
    while (size < nr) begin
      found = 0;
      best_cnt = 0;
      best_row = 0;
      for (int r = 0; r < nr; r++) begin
        if (cand[r]) begin
          n = match_total(r, nc);
          if (n < thr_reg) cand[r] = 1'b0;
          // lowest row wins a tie
          if (!found || n > best_cnt) begin
            found = 1;
            best_cnt = n;
            best_row = r;
          end
        end
      end
      if (!found || best_cnt < minw_reg) break;
      cur = (best_cnt > size) ? size : best_cnt;
      // later prefix wins an equal score
      if (cur >= score_now) begin
        score_now = cur;
        keep = size;
      end
      kept_rows[size] = best_row[7:0];
      size++;
      for (int c = 0; c < nc; c++)
        if (consensus[c] != 0 && consensus[c] != sym_mem[best_row][c]) consensus[c] = 4'd0;
      cand[best_row] = 1'b0;
    end
    kept_total = keep + 1;
  endfunction

  function automatic void predict_item(in_item_t it);
    out_item_t res;
    case (it.action)
      ACT_LOAD: sym_mem[it.row_sel][it.col_sel] = it.symbol;
      ACT_FLAG: cand[it.row_sel] = it.candidate_flag;
      default: begin
        if (it.action == ACT_START) begin
          grow_block(32'(it.row_sel), 32'(it.second_seed), 32'(it.seed_score));
          res.result_kind = KIND_SUMMARY;
          res.gene_row    = 8'd0;
        end else begin
          res.result_kind = KIND_READ;
          res.gene_row    = (it.read_position < kept_total) ? kept_rows[it.read_position] : 8'd0;
        end
        res.kept_count = kept_total[8:0];
        res.top_score  = score_now[6:0];
        expected_results.insert(expected_results.size(), res);
      end
    endcase
  endfunction

  // ------------------------------------------------------------------- driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (start && !busy) predict_item(in_item);
      if (start && busy) begin
        // hold the item until the block takes it
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_item <= pending_items.pop_front();
        start <= 1'b1;
        if (burst_left <= 1) begin
          // bursts of random length, sometimes back to back
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------ monitor
  always @(posedge clk) begin
    if (!rst && out_valid) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: kind %0d row %0d", out_item.result_kind, out_item.gene_row);
        fail_count++;
      end else begin
        out_item_t exp_res;
        exp_res = expected_results.pop_front();
        if (out_item.result_kind !== exp_res.result_kind) begin
          $error("result_kind: expected %0d, got %0d", exp_res.result_kind, out_item.result_kind);
          fail_count++;
        end
        if (out_item.gene_row !== exp_res.gene_row) begin
          $error("gene_row: expected %0d, got %0d", exp_res.gene_row, out_item.gene_row);
          fail_count++;
        end
        if (out_item.kept_count !== exp_res.kept_count) begin
          $error("kept_count: expected %0d, got %0d", exp_res.kept_count, out_item.kept_count);
          fail_count++;
        end
        if (out_item.top_score !== exp_res.top_score) begin
          $error("top_score: expected %0d, got %0d", exp_res.top_score, out_item.top_score);
          fail_count++;
        end
      end
    end
  end

  // watchdog: cycles in which neither an item nor a result moves
  always @(posedge clk) begin
    if (rst || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic in_item_t make_item(logic [1:0] act);
    in_item_t it;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    it.action = act;
    return it;
  endfunction

  function automatic void push_load(int r, int c, int s);
    in_item_t it;
    it = make_item(ACT_LOAD);
    it.row_sel = r[7:0];
    it.col_sel = c[5:0];
    it.symbol = s[3:0];
    loaded[r][c] = 1'b1;
    pending_items.insert(pending_items.size(), it);
  endfunction

  function automatic void push_flag(int r, bit f);
    in_item_t it;
    it = make_item(ACT_FLAG);
    it.row_sel = r[7:0];
    it.candidate_flag = f;
    pending_items.insert(pending_items.size(), it);
  endfunction

  function automatic void push_read(int p);
    in_item_t it;
    it = make_item(ACT_READ);
    it.read_position = p[7:0];
    pending_items.insert(pending_items.size(), it);
  endfunction

  function automatic bit row_ready(int r, int nc);
    for (int c = 0; c < nc; c++)
      if (!loaded[r][c]) return 0;
    return 1;
  endfunction

  // seed rows must have every used column loaded; mostly inside the rows in use
  function automatic int pick_seed(int nr, int nc);
    int r;
    for (int k = 0; k < 200; k++) begin
      r = ($urandom_range(0, 7) == 0 || nr == 0) ? $urandom_range(0, 255)
                                                 : $urandom_range(0, nr - 1);
      if (row_ready(r, nc)) return r;
    end
    return 0;
  endfunction

  function automatic void push_start(int nr, int nc, int sc);
    in_item_t it;
    int s1, s2;
    it = make_item(ACT_START);
    s1 = pick_seed(nr, nc);
    s2 = ($urandom_range(0, 7) == 0) ? s1 : pick_seed(nr, nc);
    it.row_sel = s1[7:0];
    it.second_seed = s2[7:0];
    it.seed_score = sc[6:0];
    pending_items.insert(pending_items.size(), it);
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_ROW_COUNT:   rc_reg = 32'(val[8:0]);
      REG_COL_COUNT:   cc_reg = 32'(val[6:0]);
      REG_WIDTH_FLOOR: minw_reg = 32'(val[6:0]);
      REG_CAND_THR:    thr_reg = 32'(val[6:0]);
      REG_COL_ENABLE:  colen_reg = val;
      default: ;
    endcase
  endtask

  // the sender holds off until the block is drained and quiet
  task automatic drain;
    int quiet;
    quiet = 0;
    while (quiet < 6) begin
      @(posedge clk);
      if (pending_items.size() == 0 && !start && !busy && expected_results.size() == 0)
        quiet++;
      else
        quiet = 0;
    end
  endtask

  initial begin
    int issued, nr, nc, nrc, ncc, starts, phase, sc, maxsym;
    int sc_pick [6] = '{0, 1, 2, 64, 127, 3};
    logic [63:0] en;
    rst = 1'b1;
    start = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    fail_count = 0;
    rc_reg = 256; cc_reg = 64; minw_reg = 1; thr_reg = 2;
    colen_reg = '1;
    kept_total = 0;
    score_now = 0;
    for (int r = 0; r < MAX_ROWS; r++) begin
      cand[r] = 1'b0;
      loaded[r] = '0;
      kept_rows[r] = 8'd0;
    end
    for (int c = 0; c < MAX_COLS; c++) consensus[c] = 4'd0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: reads before any start, corner loads and flags
    push_read(0);
    push_read(255);
    push_load(255, 63, 15);
    push_load(0, 0, 0);
    push_flag(255, 1'b1);
    push_flag(255, 1'b0);
    push_flag(0, 1'b0);
    drain();

    issued = 7;
    phase = 0;
    while (issued < 1050) begin
      // pick the setting of this phase; large row counts only with one column
      case (phase)
        0: begin nr = 256; nc = 1; nrc = 256; ncc = 1; end
        1: begin nr = 256; nc = 1; nrc = 511; ncc = 1; end
        2: begin nr = 4; nc = 64; nrc = 4; ncc = 64; end
        3: begin nr = 3; nc = 64; nrc = 3; ncc = 127; end
        4: begin nr = 2; nc = $urandom_range(1, 8); nrc = 2; ncc = nc; end
        5: begin nr = $urandom_range(0, 1); nc = 4; nrc = nr; ncc = 4; end
        default: begin
          nr = $urandom_range(3, 12);
          nc = $urandom_range(1, 16);
          nrc = nr;
          ncc = nc;
        end
      endcase
      case ($urandom_range(0, 3))
        0: en = '1;
        1: en = (phase % 7 == 6) ? 64'd0 : {$urandom, $urandom} | {$urandom, $urandom};
        default: en = {$urandom, $urandom} | {$urandom, $urandom} | {$urandom, $urandom};
      endcase
      write_reg(REG_ROW_COUNT, 64'(nrc));
      write_reg(REG_COL_COUNT, 64'(ncc));
      write_reg(REG_WIDTH_FLOOR, (phase % 9 == 8) ? 64'd64 : 64'($urandom_range(0, 3)));
      write_reg(REG_CAND_THR, (phase % 10 == 7) ? 64'd64 : 64'($urandom_range(0, 3)));
      write_reg(REG_COL_ENABLE, en);
      @(posedge clk);
      cfg_we <= 1'b0;

      // fresh matrix content over the rows and columns in use, except in phase 1
      maxsym = ($urandom_range(0, 3) == 0) ? 15 : $urandom_range(1, 3);
      if (phase != 1) begin
        for (int r = 0; r < ((nr < 2) ? 4 : nr); r++)
          for (int c = 0; c < nc; c++) begin
            push_load(r, c, $urandom_range(0, maxsym));
            issued++;
          end
      end
      starts = (nr > 64) ? 2 : $urandom_range(2, 4);
      for (int s = 0; s < starts; s++) begin
        // mostly set candidates, with some cleared and some out of range
        for (int f = 0; f < ((nr > 64) ? 40 : nr + 2); f++) begin
          push_flag((nr > 64) ? $urandom_range(0, 255) : $urandom_range(0, nr + 1),
                    $urandom_range(0, 4) != 0);
          issued++;
        end
        sc = sc_pick[$urandom_range(0, 5)];
        push_start(nr, nc, sc);
        issued++;
        for (int k = 0; k < $urandom_range(1, 5); k++) begin
          push_read(($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                                : $urandom_range(0, 6));
          issued++;
        end
      end
      drain();
      phase++;
    end

    drain();
    if (expected_results.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
